// ----- hw/rtl/gtq_pkg.sv -----
// Shared types and constants for the GPS time qualifier / RTC sync block.
// Holds the register map, the reset values and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package gtq_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_SAMPLE_IVL = 3'd0,
    REG_RESYNC_IVL = 3'd1,
    REG_MAX_STEP   = 3'd2,
    REG_IMM_THRESH = 3'd3,
    REG_SCH_THRESH = 3'd4,
    REG_REQ_SAMP   = 3'd5,
    REG_MAX_STALE  = 3'd6,
    REG_MIN_VALID  = 3'd7
  } reg_idx_t;

  localparam logic [30:0] RstSampleIvl = 31'd1000;
  localparam logic [30:0] RstResyncIvl = 31'd1800000;
  localparam logic [7:0]  RstMaxStep   = 8'd2;
  localparam logic [30:0] RstImmThresh = 31'd5;
  localparam logic [30:0] RstSchThresh = 31'd1;
  localparam logic [3:0]  RstReqSamp   = 4'd3;
  localparam logic [7:0]  RstMaxStale  = 8'd2;
  localparam logic [30:0] RstMinValid  = 31'd1704067200;

  localparam logic [7:0]  StaleMax     = 8'hFF;

  typedef struct packed {
    logic [30:0] sample_interval_ms;
    logic [30:0] resync_interval_ms;
    logic [7:0]  max_step_sec;
    logic [30:0] immediate_threshold_sec;
    logic [30:0] scheduled_threshold_sec;
    logic [3:0]  required_samples;
    logic [7:0]  max_stale;
    logic [30:0] min_valid_time;
  } cfg_t;

  typedef struct packed {
    logic [31:0] next_sample_time;
    logic [31:0] next_sync_time;
    logic [31:0] previous_gps_time;
    logic [3:0]  continuous_count;
    logic [7:0]  stale_count;
  } state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        gps_enabled;
    logic [31:0] gps_time;
    logic [31:0] local_time;
  } item_t;

  typedef struct packed {
    logic        set_clock;
    logic [31:0] new_time;
    logic        sample_taken;
    logic        locked;
  } result_t;

endpackage

// ----- hw/rtl/gtq_regs.sv -----
// APB-style configuration register file for the GPS time qualifier.
// Depends on gtq_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module gtq_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gtq_pkg::AddrW-1:0] paddr,
  input  logic [gtq_pkg::DataW-1:0] pwdata,
  output logic [gtq_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output gtq_pkg::cfg_t             cfg
);
  import gtq_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms      <= RstSampleIvl;
      cfg.resync_interval_ms      <= RstResyncIvl;
      cfg.max_step_sec            <= RstMaxStep;
      cfg.immediate_threshold_sec <= RstImmThresh;
      cfg.scheduled_threshold_sec <= RstSchThresh;
      cfg.required_samples        <= RstReqSamp;
      cfg.max_stale               <= RstMaxStale;
      cfg.min_valid_time          <= RstMinValid;
    end else if (wr_en) begin
      unique case (idx)
        REG_SAMPLE_IVL: cfg.sample_interval_ms      <= pwdata[30:0];
        REG_RESYNC_IVL: cfg.resync_interval_ms      <= pwdata[30:0];
        REG_MAX_STEP:   cfg.max_step_sec            <= pwdata[7:0];
        REG_IMM_THRESH: cfg.immediate_threshold_sec <= pwdata[30:0];
        REG_SCH_THRESH: cfg.scheduled_threshold_sec <= pwdata[30:0];
        REG_REQ_SAMP:   cfg.required_samples        <= pwdata[3:0];
        REG_MAX_STALE:  cfg.max_stale               <= pwdata[7:0];
        REG_MIN_VALID:  cfg.min_valid_time          <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAMPLE_IVL: prdata = {1'b0, cfg.sample_interval_ms};
      REG_RESYNC_IVL: prdata = {1'b0, cfg.resync_interval_ms};
      REG_MAX_STEP:   prdata = {24'd0, cfg.max_step_sec};
      REG_IMM_THRESH: prdata = {1'b0, cfg.immediate_threshold_sec};
      REG_SCH_THRESH: prdata = {1'b0, cfg.scheduled_threshold_sec};
      REG_REQ_SAMP:   prdata = {28'd0, cfg.required_samples};
      REG_MAX_STALE:  prdata = {24'd0, cfg.max_stale};
      REG_MIN_VALID:  prdata = {1'b0, cfg.min_valid_time};
    endcase
  end

endmodule

// ----- hw/rtl/gtq_eval.sv -----
// Single-pass evaluation of one tick: sample gating, GPS time qualification,
// continuity tracking and RTC correction decision. Depends on gtq_pkg.
`timescale 1ns / 1ps

module gtq_eval (
  input  gtq_pkg::cfg_t    cfg,
  input  gtq_pkg::state_t  state,
  input  gtq_pkg::item_t   item,
  output gtq_pkg::state_t  state_next,
  output gtq_pkg::result_t res
);
  import gtq_pkg::*;

  logic [31:0] since_sample;
  logic [31:0] since_sync;
  logic [31:0] step;
  logic [31:0] diff;
  logic [31:0] mag;
  logic        taken;
  logic        bad_time;
  logic        scheduled;
  logic        far_off;
  logic [7:0]  stale_inc;
  logic [3:0]  cc_inc;

  assign since_sample  = item.now_ms - state.next_sample_time;
  assign since_sync    = item.now_ms - state.next_sync_time;
  assign taken         = !since_sample[31];
  // negative also covers "above 0x7FFFFFFF"
  assign bad_time      = !item.gps_enabled || item.gps_time[31] ||
                         (item.gps_time < {1'b0, cfg.min_valid_time});
  assign step          = item.gps_time - state.previous_gps_time;
  assign diff          = item.gps_time - item.local_time;
  assign mag           = diff[31] ? (32'd0 - diff) : diff;
  assign scheduled     = !since_sync[31];
  assign far_off       = mag > {1'b0, cfg.immediate_threshold_sec};
  assign stale_inc     = (state.stale_count == StaleMax) ? state.stale_count
                                                         : state.stale_count + 8'd1;
  assign cc_inc        = (state.continuous_count < cfg.required_samples) ?
                         state.continuous_count + 4'd1 : state.continuous_count;

  always_comb begin
    state_next       = state;
    res.set_clock    = 1'b0;
    res.new_time     = 32'd0;
    res.sample_taken = taken;
    if (taken) begin
      state_next.next_sample_time = item.now_ms + {1'b0, cfg.sample_interval_ms};
      if (bad_time) begin
        state_next.previous_gps_time = 32'd0;
        state_next.continuous_count  = 4'd0;
        state_next.stale_count       = 8'd0;
      end else if (state.previous_gps_time == 32'd0) begin
        state_next.previous_gps_time = item.gps_time;
        state_next.continuous_count  = 4'd1;
      end else if (item.gps_time == state.previous_gps_time) begin
        // stale repeat: keep previous time, drop the run once past the limit
        state_next.stale_count = stale_inc;
        if (stale_inc > cfg.max_stale) begin
          state_next.continuous_count = 4'd0;
        end
      end else if (!(item.gps_time > state.previous_gps_time &&
                     step <= {24'd0, cfg.max_step_sec})) begin
        state_next.previous_gps_time = item.gps_time;
        state_next.continuous_count  = 4'd1;
        state_next.stale_count       = 8'd0;
      end else begin
        state_next.previous_gps_time = item.gps_time;
        state_next.stale_count       = 8'd0;
        state_next.continuous_count  = cc_inc;
        if (cc_inc >= cfg.required_samples && (scheduled || far_off)) begin
          if (mag > {1'b0, cfg.scheduled_threshold_sec}) begin
            res.set_clock = 1'b1;
            res.new_time  = item.gps_time;
          end
          state_next.next_sync_time = item.now_ms + {1'b0, cfg.resync_interval_ms};
        end
      end
    end
    res.locked = state_next.continuous_count >= cfg.required_samples;
  end

endmodule

// ----- hw/rtl/gps_time_qualifier_rtc_sync.sv -----
// GPS time qualifier and RTC synchronizer, top level.
// An accepted item waits in the input register; when the output register is free, the
// item is evaluated and its result and the new sequence state are registered.
// Throughput: one item per cycle unless out_stall holds a full output register.
// Reset (rst, synchronous): clears all sequence state and both pipeline valids, and loads
// the configuration registers with their defaults.
`timescale 1ns / 1ps

module gps_time_qualifier_rtc_sync (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gtq_pkg::AddrW-1:0] paddr,
  input  logic [gtq_pkg::DataW-1:0] pwdata,
  output logic [gtq_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               now_ms,
  input  logic                      gps_enabled,
  input  logic signed [31:0]        gps_time,
  input  logic [31:0]               local_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      set_clock,
  output logic [31:0]               new_time,
  output logic                      sample_taken,
  output logic                      locked
);
  import gtq_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t res;
  logic    item_valid;
  logic    advance;
  logic    in_fire;

  gtq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtq_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .res        (res)
  );

  // move the held item into the result register whenever that register frees up
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (in_fire) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.now_ms      <= now_ms;
      item.gps_enabled <= gps_enabled;
      item.gps_time    <= gps_time;
      item.local_time  <= local_time;
    end
    if (advance) begin
      set_clock    <= res.set_clock;
      new_time     <= res.new_time;
      sample_taken <= res.sample_taken;
      locked       <= res.locked;
    end
  end

endmodule

// ----- tb/tb_gps_time_qualifier_rtc_sync.sv -----
// Self-checking testbench for gps_time_qualifier_rtc_sync: drives clock ticks and
// register writes, predicts every result and compares it field by field.
// Depends on gtq_pkg and the gps_time_qualifier_rtc_sync top level.
`timescale 1ns / 1ps

module tb_gps_time_qualifier_rtc_sync;
  import gtq_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HEAVY,
    FLOW_PERIODIC
  } flow_mode_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [31:0]      now_ms = '0;
  logic             gps_enabled = 1'b0;
  logic [31:0]      gps_time = '0;
  logic [31:0]      local_time = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             set_clock;
  logic [31:0]      new_time;
  logic             sample_taken;
  logic             locked;

  // Predictor copy of the configuration and the sequence state.
  cfg_t        cfg;
  state_t      st;
  item_t       pending_ticks[$];
  result_t     expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Generator state for well-formed GPS sequences.
  logic [31:0] now_seq;
  logic [31:0] gps_seq;

  gps_time_qualifier_rtc_sync dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .gps_enabled(gps_enabled),
    .gps_time(gps_time),
    .local_time(local_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .set_clock(set_clock),
    .new_time(new_time),
    .sample_taken(sample_taken),
    .locked(locked)
  );

  always #10 clk = ~clk;

  function automatic result_t qualify_tick(item_t it);
    result_t     r;
    logic [31:0] g;
    logic [31:0] dt;
    logic [31:0] diff;
    logic [31:0] mag;
    logic        on_schedule;
    logic        way_off;
    r = '0;
    g = it.gps_time;
    dt = it.now_ms - st.next_sample_time;
    if (!dt[31]) begin
      r.sample_taken = 1'b1;
      st.next_sample_time = it.now_ms + {1'b0, cfg.sample_interval_ms};
      if (!it.gps_enabled || g[31] || g < {1'b0, cfg.min_valid_time}) begin
        st.previous_gps_time = '0;
        st.continuous_count = '0;
        st.stale_count = '0;
      end else if (st.previous_gps_time == 32'd0) begin
        st.previous_gps_time = g;
        st.continuous_count = 4'd1;
      end else if (g == st.previous_gps_time) begin
        // stale repeat: keep the previous time, drop the run once past the limit
        if (st.stale_count != StaleMax) st.stale_count++;
        if (st.stale_count > cfg.max_stale) st.continuous_count = '0;
      end else if (!(g > st.previous_gps_time &&
                     g - st.previous_gps_time <= {24'd0, cfg.max_step_sec})) begin
        st.previous_gps_time = g;
        st.continuous_count = 4'd1;
        st.stale_count = '0;
      end else begin
        st.previous_gps_time = g;
        st.stale_count = '0;
        if (st.continuous_count < cfg.required_samples) st.continuous_count++;
        if (st.continuous_count >= cfg.required_samples) begin
          diff = g - it.local_time;
          mag = diff[31] ? (32'd0 - diff) : diff;
          dt = it.now_ms - st.next_sync_time;
          on_schedule = !dt[31];
          way_off = mag > {1'b0, cfg.immediate_threshold_sec};
          if (on_schedule || way_off) begin
            if (mag > {1'b0, cfg.scheduled_threshold_sec}) begin
              r.set_clock = 1'b1;
              r.new_time = g;
            end
            st.next_sync_time = it.now_ms + {1'b0, cfg.resync_interval_ms};
          end
        end
      end
    end
    r.locked = st.continuous_count >= cfg.required_samples;
    return r;
  endfunction

  // Driver: bursts of items separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  item_t       cur_tick;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(qualify_tick(cur_tick));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_tick = pending_ticks.pop_front();
          now_ms <= cur_tick.now_ms;
          gps_enabled <= cur_tick.gps_enabled;
          gps_time <= cur_tick.gps_time;
          local_time <= cur_tick.local_time;
          in_valid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall pattern: switch between flow modes every so often.
  flow_mode_e  flow_mode = FLOW_FREE;
  int unsigned flow_left = 0;
  int unsigned flow_tick = 0;

  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow_mode = flow_mode_e'($urandom_range(0, 3));
      flow_left = $urandom_range(20, 200);
    end else begin
      flow_left--;
    end
    flow_tick++;
    case (flow_mode)
      FLOW_FREE:  out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= (flow_tick % 3 == 0);
    endcase
  end

  // Monitor: compare each accepted result with the oldest expectation.
  result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (set_clock !== want.set_clock) begin
          $error("set_clock: expected %0d, got %0d", want.set_clock, set_clock);
          mismatches++;
        end
        if (new_time !== want.new_time) begin
          $error("new_time: expected %0d, got %0d", want.new_time, new_time);
          mismatches++;
        end
        if (sample_taken !== want.sample_taken) begin
          $error("sample_taken: expected %0d, got %0d", want.sample_taken, sample_taken);
          mismatches++;
        end
        if (locked !== want.locked) begin
          $error("locked: expected %0d, got %0d", want.locked, locked);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("gps_time_qualifier_rtc_sync: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SAMPLE_IVL: cfg.sample_interval_ms = value[30:0];
      REG_RESYNC_IVL: cfg.resync_interval_ms = value[30:0];
      REG_MAX_STEP:   cfg.max_step_sec = value[7:0];
      REG_IMM_THRESH: cfg.immediate_threshold_sec = value[30:0];
      REG_SCH_THRESH: cfg.scheduled_threshold_sec = value[30:0];
      REG_REQ_SAMP:   cfg.required_samples = value[3:0];
      REG_MAX_STALE:  cfg.max_stale = value[7:0];
      default:        cfg.min_valid_time = value[30:0];
    endcase
  endtask

  task automatic load_settings(cfg_t s);
    write_reg(REG_SAMPLE_IVL, {1'b0, s.sample_interval_ms});
    write_reg(REG_RESYNC_IVL, {1'b0, s.resync_interval_ms});
    write_reg(REG_MAX_STEP, {24'd0, s.max_step_sec});
    write_reg(REG_IMM_THRESH, {1'b0, s.immediate_threshold_sec});
    write_reg(REG_SCH_THRESH, {1'b0, s.scheduled_threshold_sec});
    write_reg(REG_REQ_SAMP, {28'd0, s.required_samples});
    write_reg(REG_MAX_STALE, {24'd0, s.max_stale});
    write_reg(REG_MIN_VALID, {1'b0, s.min_valid_time});
    @(negedge clk);
  endtask

  function automatic cfg_t make_settings(logic [30:0] sample_ivl, logic [30:0] resync_ivl,
                                         logic [7:0] max_step, logic [30:0] imm_thresh,
                                         logic [30:0] sch_thresh, logic [3:0] req_samp,
                                         logic [7:0] max_stale, logic [30:0] min_valid);
    cfg_t s;
    s.sample_interval_ms = sample_ivl;
    s.resync_interval_ms = resync_ivl;
    s.max_step_sec = max_step;
    s.immediate_threshold_sec = imm_thresh;
    s.scheduled_threshold_sec = sch_thresh;
    s.required_samples = req_samp;
    s.max_stale = max_stale;
    s.min_valid_time = min_valid;
    return s;
  endfunction

  task automatic queue_tick(logic [31:0] now, logic en, logic [31:0] gps, logic [31:0] rtc);
    item_t it;
    it.now_ms = now;
    it.gps_enabled = en;
    it.gps_time = gps;
    it.local_time = rtc;
    pending_ticks.push_back(it);
  endtask

  // Start a new sequence somewhere at or just above the lowest accepted time.
  function automatic logic [31:0] fresh_gps();
    logic [31:0] span;
    span = 32'h7FFFFFFF - {1'b0, cfg.min_valid_time};
    return {1'b0, cfg.min_valid_time} + $urandom_range(0, (span > 100000) ? 100000 : span);
  endfunction

  task automatic queue_random(int unsigned count);
    item_t       it;
    int unsigned roll;
    logic [31:0] adv;
    logic [31:0] gps_val;
    logic [31:0] drift;
    now_seq = st.next_sample_time + $urandom_range(0, 32'h7FFFFFFF);
    gps_seq = fresh_gps();
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) now_seq += cfg.sample_interval_ms + $urandom_range(0, 3);
      else if (roll < 90) now_seq += $urandom_range(0, cfg.sample_interval_ms - 1);
      else if (roll < 95) now_seq -= $urandom_range(1, 1000);
      else now_seq += $urandom_range(0, 32'h7FFFFFFF);

      it.gps_enabled = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 66) begin
        adv = $urandom_range(1, (cfg.max_step_sec == 0) ? 1 : cfg.max_step_sec);
        if (gps_seq + adv > 32'h7FFFFFFF) gps_seq = fresh_gps();
        else gps_seq += adv;
      end else if (roll < 81 && roll >= 76) begin
        // forward jump past the continuous step
        adv = cfg.max_step_sec + $urandom_range(1, 100);
        if (gps_seq + adv > 32'h7FFFFFFF) gps_seq = fresh_gps();
        else gps_seq += adv;
      end else if (roll >= 94) begin
        gps_seq = fresh_gps();
      end
      gps_val = gps_seq;
      if (roll >= 81 && roll < 85) begin
        it.gps_enabled = 1'b0;
      end else if (roll >= 85 && roll < 88) begin
        gps_val = $urandom | 32'h80000000;
      end else if (roll >= 88 && roll < 91) begin
        gps_val = (cfg.min_valid_time == 0) ? 32'd0 : $urandom_range(0, cfg.min_valid_time - 1);
      end else if (roll >= 91 && roll < 94) begin
        gps_val = $urandom;
        it.gps_enabled = 1'($urandom_range(0, 1));
      end

      case ($urandom_range(0, 11))
        0, 1, 2: drift = 32'd0;
        3:       drift = 32'd1;
        4:       drift = 32'hFFFFFFFF;
        5:       drift = {1'b0, cfg.scheduled_threshold_sec};
        6:       drift = {1'b0, cfg.scheduled_threshold_sec} + 32'd1;
        7:       drift = {1'b0, cfg.immediate_threshold_sec};
        8:       drift = {1'b0, cfg.immediate_threshold_sec} + 32'd1;
        9:       drift = 32'd0 - ({1'b0, cfg.immediate_threshold_sec} + 32'd1);
        10:      drift = 32'h80000000;
        default: drift = $urandom;
      endcase

      it.now_ms = now_seq;
      it.gps_time = gps_val;
      it.local_time = gps_val + drift;
      pending_ticks.push_back(it);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  logic [31:0] base;

  initial begin
    cfg = make_settings(RstSampleIvl, RstResyncIvl, RstMaxStep, RstImmThresh,
                        RstSchThresh, RstReqSamp, RstMaxStale, RstMinValid);
    st = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks at the reset configuration.
    base = {1'b0, cfg.min_valid_time};
    queue_tick(32'd0, 1'b0, base, 32'd0);
    queue_tick(32'd500, 1'b1, base, base);
    queue_tick(32'd1000, 1'b1, 32'hFFFFFFFF, base);
    queue_tick(32'd2000, 1'b1, base - 32'd1, base);
    queue_tick(32'd3000, 1'b1, base, base);
    queue_tick(32'd4000, 1'b1, base + 32'd1, base + 32'd1);
    queue_tick(32'd5000, 1'b1, base + 32'd3, base + 32'd3);
    queue_tick(32'd6000, 1'b1, base + 32'd4, base + 32'd10);
    queue_tick(32'd7000, 1'b1, base + 32'd5, base + 32'd3);
    queue_tick(32'd8000, 1'b1, base + 32'd5, base + 32'd5);
    queue_tick(32'd9000, 1'b1, base + 32'd5, base + 32'd5);
    queue_tick(32'd10000, 1'b1, base + 32'd5, base + 32'd5);
    queue_tick(32'd11000, 1'b1, base + 32'd6, base + 32'd6);
    queue_tick(32'd12000, 1'b1, base + 32'd100, 32'd0);
    queue_tick(32'd13000, 1'b1, 32'h7FFFFFFF, 32'd0);
    queue_tick(32'd14000, 1'b1, 32'h80000000, 32'd0);
    queue_tick(32'd15000, 1'b1, 32'h7FFFFFFC, 32'h7FFFFFFC);
    queue_tick(32'd16000, 1'b1, 32'h7FFFFFFD, 32'h7FFFFFFD);
    // drift of exactly -2^31 at the top of the valid range
    queue_tick(32'd17000, 1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF);
    queue_tick(32'hFFFFFFF0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_random(200);
    wait_drained();

    load_settings(make_settings(31'd1, 31'd50, 8'd1, 31'd0, 31'd0, 4'd1, 8'd0, 31'd1));
    queue_random(200);
    wait_drained();

    load_settings(make_settings(31'd3, 31'd200, 8'd255, 31'd3, 31'd1, 4'd15, 8'd254,
                                RstMinValid));
    queue_random(200);
    wait_drained();

    load_settings(make_settings(31'h7FFFFFFF, 31'h7FFFFFFF, 8'd5, 31'h7FFFFFFF,
                                31'h7FFFFFFF, 4'd4, 8'd5, 31'h7FFFFFFF));
    queue_random(60);
    wait_drained();

    // zero required samples and zero lowest time
    load_settings(make_settings(31'd10, 31'd100, 8'd3, 31'd10, 31'd2, 4'd0, 8'd1, 31'd0));
    queue_random(150);
    wait_drained();

    repeat (2) begin
      load_settings(make_settings(31'($urandom_range(1, 20)), 31'($urandom_range(1, 5000)),
                                  8'($urandom_range(1, 255)), 31'($urandom_range(0, 10)),
                                  31'($urandom_range(0, 10)), 4'($urandom_range(1, 15)),
                                  8'($urandom_range(0, 254)),
                                  31'($urandom_range(1, 32'h7FFFFFFF))));
      queue_random(120);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("gps_time_qualifier_rtc_sync: match");
    end else begin
      $display("gps_time_qualifier_rtc_sync: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gtq_pkg.sv
hw/rtl/gtq_regs.sv
hw/rtl/gtq_eval.sv
hw/rtl/gps_time_qualifier_rtc_sync.sv
tb/tb_gps_time_qualifier_rtc_sync.sv
